### src/epps_pkg.sv
// Shared widths, types and sequencer states of the equidistant prime pair search.
package epps_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int CAND_W      = VALUE_WIDTH + 1;
	localparam int K_W         = (CAND_W + 1) / 2 + 1;
	localparam int SQ_W        = 2 * K_W;
	localparam int CNT_W       = $clog2(CAND_W + 1);
	localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS    = 1 + VALUE_WIDTH + CAND_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_TEST,
		ST_WAIT,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [CAND_W-1:0] dividend;
		logic [K_W-1:0]    divisor;
	} rem_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_rsp_t;

	typedef struct packed {
		logic                   found;
		logic [VALUE_WIDTH-1:0] lower_prime;
		logic [CAND_W-1:0]      upper_prime;
	} result_t;

endpackage

### src/epps_rem_unit.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
module epps_rem_unit
	import epps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CAND_W-1:0] dvd_q;
	logic [K_W-1:0]    div_q;
	logic [K_W:0]      rem_q;
	logic [K_W:0]      trial;
	logic [K_W:0]      rem_next;

	// Shift in the next dividend bit; the remainder stays below the divisor.
	assign trial    = {rem_q[K_W-1:0], dvd_q[CAND_W-1]};
	assign rem_next = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = (rem_q == '0);

endmodule

### src/epps_ctrl.sv
// Sequencer over offsets, candidates and trial divisors of the pair search.
module epps_ctrl
	import epps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] middle_value,
	output logic                   idle,
	output logic                   res_valid,
	input  logic                   res_take,
	output result_t                res,
	output rem_req_t               rem_req,
	input  rem_rsp_t               rem_rsp
);

	state_t                 state_q;
	state_t                 state_d;
	logic [VALUE_WIDTH-1:0] r_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [CAND_W-1:0]      n_q;
	logic [K_W-1:0]         k_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   upper_phase_q;
	result_t                res_q;
	logic [CAND_W-1:0]      sum;
	logic [CAND_W-1:0]      diff;
	logic                   sq_over;

	assign sum     = {1'b0, r_q} + {1'b0, d_q};
	assign diff    = {1'b0, r_q - d_q};
	assign sq_over = sq_q > SQ_W'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		idle             = 1'b0;
		res_valid        = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = n_q;
		rem_req.divisor  = k_q;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = (middle_value < VALUE_WIDTH'(4)) ? ST_DONE : ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_TEST;
			end
			ST_TEST: begin
				if (sq_over) begin
					state_d = upper_phase_q ? ST_SETUP : ST_DONE;
				end else begin
					rem_req.start = 1'b1;
					state_d       = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (rem_rsp.done) begin
					state_d = rem_rsp.zero ? ST_NEXT : ST_TEST;
				end
			end
			ST_NEXT: begin
				state_d = (d_q == r_q - VALUE_WIDTH'(2)) ? ST_DONE : ST_SETUP;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				r_q           <= middle_value;
				d_q           <= VALUE_WIDTH'(1);
				upper_phase_q <= 1'b1;
				res_q         <= '0;
			end
			ST_SETUP: begin
				n_q  <= upper_phase_q ? sum : diff;
				k_q  <= K_W'(2);
				sq_q <= SQ_W'(4);
			end
			ST_TEST: begin
				if (sq_over) begin
					if (upper_phase_q) begin
						upper_phase_q <= 1'b0;
					end else begin
						res_q.found       <= 1'b1;
						res_q.lower_prime <= r_q - d_q;
						res_q.upper_prime <= sum;
					end
				end
			end
			ST_WAIT: begin
				// Advance the divisor and its square: (k+1)^2 = k^2 + 2k + 1.
				if (rem_rsp.done && !rem_rsp.zero) begin
					k_q  <= k_q + K_W'(1);
					sq_q <= sq_q + SQ_W'({k_q, 1'b1});
				end
			end
			ST_NEXT: begin
				d_q           <= d_q + VALUE_WIDTH'(1);
				upper_phase_q <= 1'b1;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

### src/equidistant_prime_pair_search.sv
// Top level of the equidistant prime pair search with stream ports and output register.
//
// Usage: present a middle value r on the slave stream (s_tvalid, s_tready, s_tdata).
// For each accepted item exactly one result item leaves on the master stream
// (m_tvalid, m_tready, m_tdata): the smallest offset d >= 1 with r-d and r+d both
// prime, found by trial division; found = 0 with zero primes when no pair exists,
// including r below 4.
// Each candidate (r+d, then r-d) starts with a setup step; each trial divisor k tried
// (k from 2 while k*k <= candidate) then takes one full pass of the single bit-serial
// remainder unit. For r below 4 the sequencer goes straight from idle to done with
// found = 0, and frees the input once that result moves into the output register.
// Throughput: one item at a time; s_tready is high only while the sequencer idles.
// A finished result moves into the output register, so the next item is accepted
// while that result still waits for the receiver.
// Stall: if m_tready stays low the output register holds its item, a second result
// holds in the sequencer, and no further item is accepted until room frees up.
// Reset: arst_n clears the sequencer, the remainder unit control and output valid.
module equidistant_prime_pair_search
	import epps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // middle_value
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // found, lower_prime, upper_prime
);

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;
	result_t  res;
	result_t  out_q;
	logic     out_valid_q;
	logic     idle;
	logic     res_valid;
	logic     res_take;

	epps_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	epps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (s_tvalid && s_tready),
		.middle_value (s_tdata[VALUE_WIDTH-1:0]),
		.idle         (idle),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res),
		.rem_req      (rem_req),
		.rem_rsp      (rem_rsp)
	);

	assign s_tready = idle;

	// Load the output register whenever it is empty or being drained.
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_q.upper_prime, out_q.lower_prime, out_q.found});

endmodule

### src/epps_checker.sv
// Port-level checker of the pair search and its bind to the top level.
module epps_checker
	import epps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata
);

	logic                   found;
	logic [VALUE_WIDTH-1:0] lower;
	logic [CAND_W-1:0]      upper;

	assign found = m_tdata[0];
	assign lower = m_tdata[VALUE_WIDTH:1];
	assign upper = m_tdata[OUT_BITS-1:VALUE_WIDTH+1];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input item changed while waiting");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a search is running");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !found |-> lower == '0 && upper == '0)
		else $error("no pair but primes not zero");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && found |-> upper > CAND_W'(lower) && lower >= VALUE_WIDTH'(2))
		else $error("pair out of order");

endmodule

bind equidistant_prime_pair_search epps_checker u_epps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/epps_checker.sv
// Checker for the equidistant prime pair search: predicts every result and compares it.
module epps_tb_checker
	import epps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     mismatches,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                   found;
		logic [VALUE_WIDTH-1:0] lower_prime;
		logic [CAND_W-1:0]      upper_prime;
	} prime_pair_t;

	typedef struct {
		logic [VALUE_WIDTH-1:0] middle;
		prime_pair_t            pair;
	} pair_expect_t;

	pair_expect_t expected_pairs[$];
	pair_expect_t want;
	prime_pair_t  got;

	function automatic bit is_prime(int unsigned n);
		int unsigned k;
		for (k = 2; k * k <= n; k++) begin
			if (n % k == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Smallest offset d in 1..r-2 with both r-d and r+d prime; all zero when none.
	function automatic prime_pair_t find_prime_pair(logic [VALUE_WIDTH-1:0] middle);
		prime_pair_t pair;
		int unsigned r;
		int unsigned d;
		pair = '0;
		r = middle;
		if (r >= 4) begin
			for (d = 1; d <= r - 2; d++) begin
				if (is_prime(r + d) && is_prime(r - d)) begin
					pair.found       = 1'b1;
					pair.lower_prime = VALUE_WIDTH'(r - d);
					pair.upper_prime = CAND_W'(r + d);
					break;
				end
			end
		end
		return pair;
	endfunction

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.found       = m_tdata[0];
				got.lower_prime = m_tdata[VALUE_WIDTH:1];
				got.upper_prime = m_tdata[VALUE_WIDTH+CAND_W:VALUE_WIDTH+1];
				if (expected_pairs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing pending: found=%0d lower=%0d upper=%0d",
							$realtime, got.found, got.lower_prime, got.upper_prime);
				end else begin
					want = expected_pairs.pop_front();
					if (got !== want.pair) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: r=%0d expected found=%0d lower=%0d upper=%0d,",
								" got found=%0d lower=%0d upper=%0d"},
								$realtime, want.middle, want.pair.found, want.pair.lower_prime,
								want.pair.upper_prime, got.found, got.lower_prime, got.upper_prime);
					end
				end
			end
			// a result never leaves in the same cycle its item enters, so compare first
			if (s_tvalid && s_tready) begin
				want.middle    = s_tdata[VALUE_WIDTH-1:0];
				want.pair      = find_prime_pair(s_tdata[VALUE_WIDTH-1:0]);
				expected_pairs = {expected_pairs, want};
			end
			pending = expected_pairs.size();
		end
	end

endmodule

### verif/tb.sv
// Testbench top for the equidistant prime pair search: clock, reset, stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import epps_pkg::*;

	// Receiver hold-off long enough for several small searches to finish, so the
	// output register and the sequencer both fill and s_tready drops.
	localparam int HOLD_OFF_CYCLES = 20000;
	localparam int RANDOM_ITEMS    = 120;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // middle_value
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // found, lower_prime, upper_prime

	int mismatches;
	int pending;
	bit hold_off_req;
	bit hold_off_done;
	int burst_left;

	// Corner middle values: no-pair cases below 4, the first values with a pair,
	// both extremes of the field, and alternating bit patterns.
	logic [VALUE_WIDTH-1:0] corner_middles[$] = '{
		16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9,
		16'd11, 16'd100, 16'd1000, 16'd1024, 16'h5555, 16'haaaa, 16'h8000,
		16'hfffd, 16'hfffe, 16'hffff
	};

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	equidistant_prime_pair_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	epps_tb_checker u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Offer one middle value and hold it until accepted. The sender works in bursts:
	// when a burst runs out, drop valid for a random gap (sometimes none) and start
	// a new one. Call at a falling edge; returns at a falling edge with valid high.
	task automatic offer_middle(input logic [VALUE_WIDTH-1:0] middle);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= IN_TDATA_W'($urandom);
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(8, 1);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= middle;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Receiver: switch at random between always ready, mostly ready and mostly
	// stalled modes. Once the random part starts, hold m_tready low once for the
	// hold-off while the sender keeps offering.
	initial begin
		int mode_left;
		int ready_pct;
		mode_left = 0;
		ready_pct = 100;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(300, 20);
					case ($urandom_range(2, 0))
						0: ready_pct = 100;
						1: ready_pct = 75;
						default: ready_pct = 30;
					endcase
				end
				mode_left--;
				m_tready <= ($urandom_range(99, 0) < ready_pct);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [VALUE_WIDTH-1:0] middle;
		int pick;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		arst_n       = 1'b0;
		hold_off_req = 1'b0;
		burst_left   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (corner_middles[i])
			offer_middle(corner_middles[i]);

		// Pause the sender until every corner result has come back.
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
		burst_left = 0;

		// Random part. Start with small values so they finish inside the receiver
		// hold-off and the block backs up; keep most values small so searches stay
		// short, with a few up to the top of the value range.
		hold_off_req = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(99, 0);
			if (n < 8)
				middle = VALUE_WIDTH'($urandom_range(300, 0));
			else if (pick < 10)
				middle = VALUE_WIDTH'($urandom_range(8, 0));
			else if (pick < 72)
				middle = VALUE_WIDTH'($urandom_range(2047, 4));
			else if (pick < 92)
				middle = VALUE_WIDTH'($urandom_range(16383, 2048));
			else
				middle = VALUE_WIDTH'($urandom_range(65535, 16384));
			offer_middle(middle);
		end

		// Drain: wait for the last results, then a little slack.
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard limit well above the slowest correct run.
	initial begin
		#200_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
